[hdl/irta_pkg.sv]
// Shared types, constants and helper functions for the radix-to-ASCII converter.
`default_nettype none

package irta_pkg;

  localparam int WORD_BITS  = 32;
  localparam int RADIX_W    = 5;
  localparam int CHAR_W     = 7;
  localparam int DIGIT_W    = 4;

  // The divider retires this many quotient bits per cycle.
  localparam int STEP_BITS   = 8;
  localparam int DIV_STEPS   = (WORD_BITS + STEP_BITS - 1) / STEP_BITS;
  localparam int PAD_BITS    = DIV_STEPS * STEP_BITS;
  localparam int STEP_CNT_W  = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  // Digit buffer holds up to one digit per bit of the word.
  localparam int IDX_W = $clog2(WORD_BITS);
  localparam int CNT_W = $clog2(WORD_BITS + 1);

  localparam int CMDQ_DEPTH = 2;

  localparam logic [RADIX_W-1:0] RADIX_MIN = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX = RADIX_W'(16);
  localparam logic [RADIX_W-1:0] RADIX_DEC = RADIX_W'(10);

  localparam logic [CHAR_W-1:0] CHAR_MINUS = CHAR_W'(8'h2d);
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = CHAR_W'(8'h30);
  localparam logic [CHAR_W-1:0] CHAR_LOW_A = CHAR_W'(8'h61);
  localparam logic [CHAR_W-1:0] CHAR_UP_A  = CHAR_W'(8'h41);
  localparam logic [CHAR_W-1:0] CHAR_NONE  = CHAR_W'(0);

  // One classified conversion job handed from the front end to the back end.
  typedef struct packed {
    logic [WORD_BITS-1:0] mag;
    logic [RADIX_W-1:0]   radix;
    logic                 upper;
    logic                 neg;
    logic                 err;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_DIV,
    BK_SIGN,
    BK_EMIT,
    BK_ERR
  } back_state_e;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] dig,
                                                   input logic upper);
    logic [CHAR_W-1:0] res;
    if (dig < DIGIT_W'(10)) begin
      res = CHAR_ZERO + CHAR_W'(dig);
    end else if (upper) begin
      res = CHAR_UP_A + CHAR_W'(dig - DIGIT_W'(10));
    end else begin
      res = CHAR_LOW_A + CHAR_W'(dig - DIGIT_W'(10));
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[hdl/irta_front.sv]
// Front end: classifies an incoming item and forms the job for the back end.
`default_nettype none

module irta_front import irta_pkg::*; (
  input  wire logic                 push_i,
  input  wire logic [WORD_BITS-1:0] value_i,
  input  wire logic [RADIX_W-1:0]   radix_i,
  input  wire logic                 upper_case_i,
  input  wire logic                 signed_decimal_i,
  input  wire q_status_t            q_stat_i,
  output logic                      full_o,
  output logic                      cmd_push_o,
  output cmd_t                      cmd_o
);

  logic bad_radix;
  logic is_neg;

  assign bad_radix = (radix_i < RADIX_MIN) || (radix_i > RADIX_MAX);

  // Only signed decimal with the top bit set prints a minus sign.
  assign is_neg = signed_decimal_i && (radix_i == RADIX_DEC) && value_i[WORD_BITS-1];

  always_comb begin
    cmd_o.mag   = is_neg ? (~value_i + WORD_BITS'(1)) : value_i;
    cmd_o.radix = radix_i;
    cmd_o.upper = upper_case_i;
    cmd_o.neg   = is_neg && !bad_radix;
    cmd_o.err   = bad_radix;
  end

  assign full_o     = q_stat_i.full;
  assign cmd_push_o = push_i && !q_stat_i.full;

endmodule

`default_nettype wire

[hdl/irta_cmd_fifo.sv]
// Short job queue between the front end and the back end.
`default_nettype none

module irta_cmd_fifo import irta_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire cmd_t data_i,
  input  wire logic pop_i,
  output cmd_t      data_o,
  output q_status_t stat_o
);

  localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int QCNT_W = $clog2(CMDQ_DEPTH + 1);

  cmd_t              mem_q [CMDQ_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == QCNT_W'(CMDQ_DEPTH));
  assign stat_o.empty = (cnt_q == QCNT_W'(0));
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? PTR_W'(0) : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? PTR_W'(0) : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + QCNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/irta_back.sv]
// Back end: digit extraction by iterative division, digit buffer and character output.
`default_nettype none

module irta_back import irta_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire cmd_t              cmd_i,
  input  wire q_status_t         q_stat_i,
  output logic                   cmd_pop_o,
  input  wire logic              pop_i,
  output logic                   empty_o,
  output logic [CHAR_W-1:0]      out_char_o,
  output logic                   last_o,
  output logic                   error_o
);

  back_state_e             state_q, state_d;
  logic [PAD_BITS-1:0]     div_q, div_d;
  logic [DIGIT_W-1:0]      rem_q, rem_d;
  logic [STEP_CNT_W-1:0]   step_q, step_d;
  logic [CNT_W-1:0]        cnt_q, cnt_d;
  logic [RADIX_W-1:0]      radix_q, radix_d;
  logic                    upper_q, upper_d;
  logic                    neg_q, neg_d;
  logic [DIGIT_W-1:0]      dig_q [WORD_BITS];

  logic                    out_vld_q, out_vld_d;
  logic [CHAR_W-1:0]       out_char_q, out_char_d;
  logic                    last_q, last_d;
  logic                    err_q, err_d;

  logic                    slot_free;
  logic                    load;
  logic                    dig_we;
  logic [STEP_BITS-1:0]    qbits;
  logic [DIGIT_W-1:0]      rem_next;
  logic [PAD_BITS-1:0]     div_shift;
  logic [IDX_W-1:0]        rd_idx;

  // One slice of long division: STEP_BITS quotient bits from the top of div_q.
  always_comb begin
    logic [DIGIT_W-1:0]  r;
    logic [DIGIT_W:0]    t;
    logic [STEP_BITS-1:0] top;
    r   = rem_q;
    top = div_q[PAD_BITS-1 -: STEP_BITS];
    for (int i = STEP_BITS - 1; i >= 0; i--) begin
      t = {r, top[i]};
      if (t >= radix_q) begin
        qbits[i] = 1'b1;
        r = DIGIT_W'(t - radix_q);
      end else begin
        qbits[i] = 1'b0;
        r = t[DIGIT_W-1:0];
      end
    end
    rem_next = r;
  end

  assign div_shift = PAD_BITS'({div_q, qbits});
  assign slot_free = !out_vld_q || pop_i;
  assign rd_idx    = IDX_W'(cnt_q - CNT_W'(1));

  always_comb begin
    state_d    = state_q;
    div_d      = div_q;
    rem_d      = rem_q;
    step_d     = step_q;
    cnt_d      = cnt_q;
    radix_d    = radix_q;
    upper_d    = upper_q;
    neg_d      = neg_q;
    cmd_pop_o  = 1'b0;
    dig_we     = 1'b0;
    load       = 1'b0;
    out_char_d = out_char_q;
    last_d     = last_q;
    err_d      = err_q;

    case (state_q)
      BK_IDLE: begin
        if (!q_stat_i.empty) begin
          cmd_pop_o = 1'b1;
          div_d     = PAD_BITS'(cmd_i.mag);
          rem_d     = '0;
          step_d    = '0;
          cnt_d     = '0;
          radix_d   = cmd_i.radix;
          upper_d   = cmd_i.upper;
          neg_d     = cmd_i.neg;
          state_d   = cmd_i.err ? BK_ERR : BK_DIV;
        end
      end
      BK_DIV: begin
        div_d  = div_shift;
        rem_d  = rem_next;
        step_d = step_q + STEP_CNT_W'(1);
        if (step_q == STEP_CNT_W'(DIV_STEPS - 1)) begin
          dig_we = 1'b1;
          cnt_d  = cnt_q + CNT_W'(1);
          rem_d  = '0;
          step_d = '0;
          if (div_shift == '0) begin
            state_d = neg_q ? BK_SIGN : BK_EMIT;
          end
        end
      end
      BK_SIGN: begin
        if (slot_free) begin
          load       = 1'b1;
          out_char_d = CHAR_MINUS;
          last_d     = 1'b0;
          err_d      = 1'b0;
          state_d    = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          load       = 1'b1;
          out_char_d = digit_char(dig_q[rd_idx], upper_q);
          last_d     = (cnt_q == CNT_W'(1));
          err_d      = 1'b0;
          cnt_d      = cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_d = BK_IDLE;
          end
        end
      end
      BK_ERR: begin
        if (slot_free) begin
          load       = 1'b1;
          out_char_d = CHAR_NONE;
          last_d     = 1'b1;
          err_d      = 1'b1;
          state_d    = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase

    if (load) begin
      out_vld_d = 1'b1;
    end else if (pop_i) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= BK_IDLE;
      out_vld_q <= 1'b0;
      step_q    <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      step_q    <= step_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q      <= div_d;
    rem_q      <= rem_d;
    radix_q    <= radix_d;
    upper_q    <= upper_d;
    neg_q      <= neg_d;
    out_char_q <= out_char_d;
    last_q     <= last_d;
    err_q      <= err_d;
    if (dig_we) begin
      dig_q[cnt_q[IDX_W-1:0]] <= rem_next;
    end
  end

  assign empty_o    = !out_vld_q;
  assign out_char_o = out_char_q;
  assign last_o     = last_q;
  assign error_o    = err_q;

endmodule

`default_nettype wire

[hdl/integer_radix_to_ascii_core.sv]
// Top level of the radix-to-ASCII converter: front end, job queue and back end.
//
//   Channel   Handshake        Payload
//   -------   --------------   ----------------------------------------------
//   input     push / full      value_i, radix_i, upper_case_i, signed_decimal_i
//   result    empty / pop      out_char_o, last_o, error_o
//
// An item is classified in the cycle it is pushed and its job waits in a
// two-entry queue. The back end divides the magnitude by the radix with a
// long-division unit that retires eight quotient bits per cycle; digits then
// leave one per cycle while each result is popped at once. A bad radix gives
// a single result.
// Reset clears the queue, the back-end state and the output valid flag.
// A stalled result holds the back end, while the front still takes items
// until the job queue is full.
`default_nettype none

module integer_radix_to_ascii_core import irta_pkg::*; (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push,
  output logic                      full,
  input  wire logic [WORD_BITS-1:0] value_i,
  input  wire logic [RADIX_W-1:0]   radix_i,
  input  wire logic                 upper_case_i,
  input  wire logic                 signed_decimal_i,
  output logic                      empty,
  input  wire logic                 pop,
  output logic [CHAR_W-1:0]         out_char_o,
  output logic                      last_o,
  output logic                      error_o
);

  cmd_t      front_cmd;
  cmd_t      head_cmd;
  logic      cmd_push;
  logic      cmd_pop;
  q_status_t q_stat;

  // The front end only classifies; it never waits on the back end directly.
  irta_front u_front (
    .push_i           (push),
    .value_i          (value_i),
    .radix_i          (radix_i),
    .upper_case_i     (upper_case_i),
    .signed_decimal_i (signed_decimal_i),
    .q_stat_i         (q_stat),
    .full_o           (full),
    .cmd_push_o       (cmd_push),
    .cmd_o            (front_cmd)
  );

  irta_cmd_fifo u_cmd_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (front_cmd),
    .pop_i  (cmd_pop),
    .data_o (head_cmd),
    .stat_o (q_stat)
  );

  // The back end owns the divider, the digit buffer and the output register.
  irta_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (head_cmd),
    .q_stat_i   (q_stat),
    .cmd_pop_o  (cmd_pop),
    .pop_i      (pop),
    .empty_o    (empty),
    .out_char_o (out_char_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

endmodule

`default_nettype wire

[hdl/irta_checker.sv]
// Port-level checker for the radix-to-ASCII converter and its bind statement.
`default_nettype none

module irta_checker import irta_pkg::*; (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic [CHAR_W-1:0] out_char_o,
  input wire logic              last_o,
  input wire logic              error_o
);

  // An error result is always the single, final item of its conversion.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && error_o) |-> (last_o && out_char_o == CHAR_NONE))
    else $error("error result without last or with a character");

  // A minus sign always opens a conversion and is never its end.
  a_minus_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && out_char_o == CHAR_MINUS) |-> (!last_o && !error_o))
    else $error("minus sign marked last or error");

  // Non-error results never carry the null character.
  a_char_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !error_o) |-> (out_char_o != CHAR_NONE))
    else $error("normal result carries a null character");

  // A waiting result that is not taken stays on the ports.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(out_char_o) && $stable(last_o)
                          && $stable(error_o)))
    else $error("result changed while stalled");

endmodule

bind integer_radix_to_ascii_core irta_checker u_irta_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .empty      (empty),
  .pop        (pop),
  .out_char_o (out_char_o),
  .last_o     (last_o),
  .error_o    (error_o)
);

`default_nettype wire
